>>> design/wfr_pkg.sv
package wfr_pkg;

  localparam int unsigned SAMPLES_W = 16;
  localparam int unsigned CH_W      = 7;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned SR_W      = 20;
  localparam int unsigned RATE_W    = 24;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned ELAPSED_W = 48;
  localparam int unsigned DIV_CNT_W = $clog2(RATE_W + 1);

  localparam logic [SR_W-1:0]   SR_RESET = SR_W'(30000);
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // Input tdata packing, lowest bits first
  localparam int unsigned IN_SAMPLES_LSB = 0;
  localparam int unsigned IN_CH_LSB      = IN_SAMPLES_LSB + SAMPLES_W;
  localparam int unsigned IN_CNT_LSB     = IN_CH_LSB + CH_W;
  localparam int unsigned IN_DATA_W      = 32;

  // Output tdata packing, lowest bits first
  localparam int unsigned OUT_CH_LSB      = 0;
  localparam int unsigned RATE_LSB        = OUT_CH_LSB + CH_W;
  localparam int unsigned ELAPSED_LSB     = RATE_LSB + RATE_W;
  localparam int unsigned OUT_DATA_W      = 80;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [RATE_W-1:0] quo;
  } div_res_t;

endpackage

>>> design/windowed_firing_rate_top.sv
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: tick_samples, channel, spike_count
//                                                tuser: start_tick
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: out_channel, rate, elapsed_total
//                                                tuser: status
// cfg       in   cfg_we_i                        cfg_wdata_i: sample_rate_hz
//
// After reset a clear pass over all CHANNELS*WINDOW (1536) count entries holds s_axis_tready low.
// Each word goes through accept, memory read, update, multiply, check, 24
// restoring steps of the shared divider, quotient pickup, output load. Items with
// an empty window or an out-of-range channel skip the divider.
// A new word is accepted while the previous result waits in the output
// register; the block stalls at the output load until that register is free.
module windowed_firing_rate_top #(
  parameter int unsigned CHANNELS = 96,
  parameter int unsigned WINDOW   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wfr_pkg::SR_W-1:0]            cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] tick_samples, [22:16] channel, [30:23] spike_count, [31] zero
  input  logic [wfr_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // [0] start_tick
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [6:0] out_channel, [30:7] rate, [78:31] elapsed_total, [79] zero
  output logic [wfr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // [1:0] status
  output logic [wfr_pkg::STATUS_W-1:0]        m_axis_tuser
);

  localparam int unsigned DEPTH  = CHANNELS * WINDOW;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned SUM_W  = $clog2(255 * WINDOW + 1);
  localparam int unsigned TSUM_W = $clog2(65535 * WINDOW + 1);
  localparam int unsigned PROD_W = SUM_W + wfr_pkg::SR_W;
  localparam int unsigned NUM_W  = PROD_W + wfr_pkg::FRAC_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]                       state_q, state_d;
  logic [AW-1:0]                    clr_q, clr_d;
  logic [SLOT_W-1:0]                slot_q, slot_d;
  logic [TSUM_W-1:0]                time_sum_q, time_sum_d;
  logic [wfr_pkg::ELAPSED_W-1:0]    elapsed_q, elapsed_d;
  logic [wfr_pkg::SR_W-1:0]         rate_hz_q;
  logic                             m_valid_q, m_valid_d;

  logic                             start_q, start_d;
  logic [wfr_pkg::SAMPLES_W-1:0]    samples_q, samples_d;
  logic [wfr_pkg::CH_W-1:0]         ch_q, ch_d;
  logic [wfr_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic                             inrange_q, inrange_d;
  logic [SUM_W-1:0]                 sum_q, sum_d;
  logic [PROD_W-1:0]                prod_q, prod_d;
  logic [wfr_pkg::RATE_W-1:0]       res_rate_q, res_rate_d;
  logic [wfr_pkg::STATUS_W-1:0]     res_status_q, res_status_d;
  logic [wfr_pkg::CH_W-1:0]         out_ch_q, out_ch_d;
  logic [wfr_pkg::RATE_W-1:0]       out_rate_q, out_rate_d;
  logic [wfr_pkg::STATUS_W-1:0]     out_status_q, out_status_d;
  logic [wfr_pkg::ELAPSED_W-1:0]    out_elapsed_q, out_elapsed_d;

  logic                             in_fire;
  logic                             clearing;
  logic                             load_out;
  logic [AW-1:0]                    pos;
  logic [CH_AW-1:0]                 ch_idx;
  logic [SUM_W-1:0]                 new_sum;

  logic                             cw_we, tw_we, sw_we;
  logic [AW-1:0]                    cw_waddr;
  logic [SLOT_W-1:0]                tw_waddr;
  logic [CH_AW-1:0]                 sw_waddr;
  logic [wfr_pkg::CNT_W-1:0]        cw_wdata, cw_rdata;
  logic [wfr_pkg::SAMPLES_W-1:0]    tw_wdata, tw_rdata;
  logic [SUM_W-1:0]                 sw_wdata, sw_rdata;

  logic                             div_start;
  wfr_pkg::div_res_t                div_res;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign clearing = state_q == S_CLEAR;
  assign load_out = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);
  assign pos      = AW'(32'(ch_q) * WINDOW + 32'(slot_q));
  assign ch_idx   = CH_AW'(ch_q);
  assign new_sum  = sw_rdata - SUM_W'(cw_rdata) + SUM_W'(cnt_q);
  assign div_start = (state_q == S_CHK) && inrange_q && (time_sum_q != '0);

  // memory write ports: zero fill during the clear pass, else the update step
  always_comb begin
    cw_we    = 1'b0;
    tw_we    = 1'b0;
    sw_we    = 1'b0;
    cw_waddr = pos;
    tw_waddr = slot_q;
    sw_waddr = ch_idx;
    cw_wdata = cnt_q;
    tw_wdata = samples_q;
    sw_wdata = new_sum;
    if (clearing) begin
      cw_we    = 1'b1;
      tw_we    = 32'(clr_q) < WINDOW;
      sw_we    = 32'(clr_q) < CHANNELS;
      cw_waddr = clr_q;
      tw_waddr = SLOT_W'(clr_q);
      sw_waddr = CH_AW'(clr_q);
      cw_wdata = '0;
      tw_wdata = '0;
      sw_wdata = '0;
    end else if (state_q == S_UPD) begin
      cw_we = inrange_q;
      sw_we = inrange_q;
      tw_we = start_q;
    end
  end

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    slot_d        = slot_q;
    time_sum_d    = time_sum_q;
    elapsed_d     = elapsed_q;
    m_valid_d     = m_valid_q;
    start_d       = start_q;
    samples_d     = samples_q;
    ch_d          = ch_q;
    cnt_d         = cnt_q;
    inrange_d     = inrange_q;
    sum_d         = sum_q;
    prod_d        = prod_q;
    res_rate_d    = res_rate_q;
    res_status_d  = res_status_q;
    out_ch_d      = out_ch_q;
    out_rate_d    = out_rate_q;
    out_status_d  = out_status_q;
    out_elapsed_d = out_elapsed_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == DEPTH - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          start_d   = s_axis_tuser;
          samples_d = s_axis_tdata[wfr_pkg::IN_SAMPLES_LSB +: wfr_pkg::SAMPLES_W];
          ch_d      = s_axis_tdata[wfr_pkg::IN_CH_LSB +: wfr_pkg::CH_W];
          cnt_d     = s_axis_tdata[wfr_pkg::IN_CNT_LSB +: wfr_pkg::CNT_W];
          inrange_d = 32'(s_axis_tdata[wfr_pkg::IN_CH_LSB +: wfr_pkg::CH_W]) < CHANNELS;
          // advance the ring slot before the count lands
          if (s_axis_tuser) begin
            slot_d = (32'(slot_q) == WINDOW - 1) ? '0 : slot_q + 1'b1;
          end
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (start_q) begin
          time_sum_d = time_sum_q - TSUM_W'(tw_rdata) + TSUM_W'(samples_q);
          elapsed_d  = elapsed_q + wfr_pkg::ELAPSED_W'(samples_q);
        end
        sum_d   = new_sum;
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = PROD_W'(sum_q) * PROD_W'(rate_hz_q);
        state_d = S_CHK;
      end
      S_CHK: begin
        res_rate_d   = '0;
        res_status_d = wfr_pkg::STATUS_OK;
        if (!inrange_q) begin
          state_d = S_DONE;
        end else if (time_sum_q == '0) begin
          res_status_d = wfr_pkg::STATUS_ZERO;
          state_d      = S_DONE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          res_rate_d   = div_res.sat ? wfr_pkg::RATE_MAX : div_res.quo;
          res_status_d = div_res.sat ? wfr_pkg::STATUS_SAT : wfr_pkg::STATUS_OK;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (load_out) begin
          out_ch_d      = ch_q;
          out_rate_d    = res_rate_q;
          out_status_d  = res_status_q;
          out_elapsed_d = elapsed_q;
          m_valid_d     = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      slot_q     <= SLOT_W'(WINDOW - 1);
      time_sum_q <= '0;
      elapsed_q  <= '0;
      rate_hz_q  <= wfr_pkg::SR_RESET;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      slot_q     <= slot_d;
      time_sum_q <= time_sum_d;
      elapsed_q  <= elapsed_d;
      m_valid_q  <= m_valid_d;
      if (cfg_we_i) begin
        rate_hz_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q       <= start_d;
    samples_q     <= samples_d;
    ch_q          <= ch_d;
    cnt_q         <= cnt_d;
    inrange_q     <= inrange_d;
    sum_q         <= sum_d;
    prod_q        <= prod_d;
    res_rate_q    <= res_rate_d;
    res_status_q  <= res_status_d;
    out_ch_q      <= out_ch_d;
    out_rate_q    <= out_rate_d;
    out_status_q  <= out_status_d;
    out_elapsed_q <= out_elapsed_d;
  end

  wfr_ram #(
    .WIDTH (wfr_pkg::CNT_W),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cw_we),
    .waddr_i (cw_waddr),
    .wdata_i (cw_wdata),
    .raddr_i (pos),
    .rdata_o (cw_rdata)
  );

  wfr_ram #(
    .WIDTH (wfr_pkg::SAMPLES_W),
    .DEPTH (WINDOW)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (tw_we),
    .waddr_i (tw_waddr),
    .wdata_i (tw_wdata),
    .raddr_i (slot_q),
    .rdata_o (tw_rdata)
  );

  wfr_ram #(
    .WIDTH (SUM_W),
    .DEPTH (CHANNELS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sw_we),
    .waddr_i (sw_waddr),
    .wdata_i (sw_wdata),
    .raddr_i (ch_idx),
    .rdata_o (sw_rdata)
  );

  wfr_div #(
    .NUM_W (NUM_W),
    .DEN_W (TSUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({prod_q, wfr_pkg::FRAC_W'(0)}),
    .den_i   (time_sum_q),
    .res_o   (div_res)
  );

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, out_elapsed_q, out_rate_q, out_ch_q};
  assign m_axis_tuser  = out_status_q;

endmodule

>>> design/wfr_ram.sv
module wfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/wfr_div.sv
module wfr_div #(
  parameter int unsigned NUM_W = 40,
  parameter int unsigned DEN_W = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output wfr_pkg::div_res_t res_o
);

  localparam int unsigned RW    = wfr_pkg::RATE_W;
  localparam int unsigned HI_W  = NUM_W - RW;
  localparam int unsigned CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic                            sat_q, sat_d;
  logic [wfr_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [DEN_W-1:0]                rem_q, rem_d;
  logic [RW-1:0]                   low_q, low_d;

  logic [HI_W-1:0]  num_hi;
  logic             over;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign num_hi = num_i[NUM_W-1:RW];
  // quotient fits 24 bits only if the upper part stays below the divisor
  assign over   = CMP_W'(num_hi) >= CMP_W'(den_i);
  assign trial  = {rem_q, low_q[RW-1]};
  assign ge     = trial >= {1'b0, den_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sat_d  = sat_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    if (start_i) begin
      sat_d = over;
      if (over) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        cnt_d  = wfr_pkg::DIV_CNT_W'(RW);
        rem_d  = DEN_W'(num_hi);
        low_d  = num_i[RW-1:0];
      end
    end else if (busy_q) begin
      // one restoring step: shift a numerator bit into the remainder, shift a quotient bit into low
      rem_d = ge ? DEN_W'(trial - {1'b0, den_i}) : DEN_W'(trial);
      low_d = {low_q[RW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == wfr_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= sat_d;
    rem_q <= rem_d;
    low_q <= low_d;
  end

  assign res_o.done = done_q;
  assign res_o.sat  = sat_q;
  assign res_o.quo  = low_q;

endmodule

>>> design/wfr_checker.sv
module wfr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [wfr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input logic [wfr_pkg::STATUS_W-1:0]      m_axis_tuser
);

  logic [wfr_pkg::RATE_W-1:0] rate;

  assign rate = m_axis_tdata[wfr_pkg::RATE_LSB +: wfr_pkg::RATE_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while previous word still in work");

  a_zero_window_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == wfr_pkg::STATUS_ZERO) |-> rate == '0)
    else $error("empty window gave a nonzero rate");

  a_sat_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == wfr_pkg::STATUS_SAT) |-> rate == wfr_pkg::RATE_MAX)
    else $error("saturated status without full-scale rate");

endmodule

bind windowed_firing_rate_top wfr_checker u_wfr_checker (.*);
